// ===== hw/rtl/rv64im_instruction_decoder_macros.svh =====
// Assertion macros for the instruction decoder.
// The _RST form stays active during reset, the plain form is disabled while rst is high.
`ifndef RV64IM_INSTRUCTION_DECODER_MACROS_SVH
`define RV64IM_INSTRUCTION_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define RV64ID_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("decoder assertion failed");

`define RV64ID_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("decoder reset assertion failed");

`else

`define RV64ID_ASSERT(label, prop)

`define RV64ID_ASSERT_RST(label, prop)

`endif

`endif

// ===== hw/rtl/rv64id_pkg.sv =====
`timescale 1ns / 1ps

package rv64id_pkg;

  // Major opcodes, bits 6:0.
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_OP32     = 7'h3B;
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0F;

  // Instruction classes.
  localparam logic [3:0] CLS_LUI      = 4'd0;
  localparam logic [3:0] CLS_JAL      = 4'd1;
  localparam logic [3:0] CLS_JALR     = 4'd2;
  localparam logic [3:0] CLS_AUIPC    = 4'd3;
  localparam logic [3:0] CLS_OP_IMM   = 4'd4;
  localparam logic [3:0] CLS_OP_IMM32 = 4'd5;
  localparam logic [3:0] CLS_OP       = 4'd6;
  localparam logic [3:0] CLS_OP32     = 4'd7;
  localparam logic [3:0] CLS_LOAD     = 4'd8;
  localparam logic [3:0] CLS_STORE    = 4'd9;
  localparam logic [3:0] CLS_BR_FENCE = 4'd10;

  // Kinds within the branch-or-fence class.
  localparam logic [1:0] KIND_BRANCH  = 2'd0;
  localparam logic [1:0] KIND_FENCE   = 2'd1;
  localparam logic [1:0] KIND_FENCE_I = 2'd2;

  // ALU and M-extension operations.
  localparam logic [4:0] OP_ADD    = 5'd0;
  localparam logic [4:0] OP_SUB    = 5'd1;
  localparam logic [4:0] OP_SLL    = 5'd2;
  localparam logic [4:0] OP_SLT    = 5'd3;
  localparam logic [4:0] OP_SLTU   = 5'd4;
  localparam logic [4:0] OP_XOR    = 5'd5;
  localparam logic [4:0] OP_SRL    = 5'd6;
  localparam logic [4:0] OP_SRA    = 5'd7;
  localparam logic [4:0] OP_OR     = 5'd8;
  localparam logic [4:0] OP_AND    = 5'd9;
  localparam logic [4:0] OP_ADDW   = 5'd10;
  localparam logic [4:0] OP_SUBW   = 5'd11;
  localparam logic [4:0] OP_SLLW   = 5'd12;
  localparam logic [4:0] OP_SRLW   = 5'd13;
  localparam logic [4:0] OP_SRAW   = 5'd14;
  localparam logic [4:0] OP_MUL    = 5'd15;
  localparam logic [4:0] OP_MULH   = 5'd16;
  localparam logic [4:0] OP_MULHSU = 5'd17;
  localparam logic [4:0] OP_MULHU  = 5'd18;
  localparam logic [4:0] OP_DIV    = 5'd19;
  localparam logic [4:0] OP_DIVU   = 5'd20;
  localparam logic [4:0] OP_REM    = 5'd21;
  localparam logic [4:0] OP_REMU   = 5'd22;
  localparam logic [4:0] OP_MULW   = 5'd23;
  localparam logic [4:0] OP_DIVW   = 5'd24;
  localparam logic [4:0] OP_DIVUW  = 5'd25;
  localparam logic [4:0] OP_REMW   = 5'd26;
  localparam logic [4:0] OP_REMUW  = 5'd27;

  // funct3 codes that matter to the decoder.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  typedef struct packed {
    logic              is_unknown;
    logic [3:0]        instr_class;
    logic [1:0]        op_kind;
    logic [4:0]        operation;
    logic [4:0]        rd_index;
    logic [4:0]        rs1_index;
    logic [4:0]        rs2_index;
    logic signed [31:0] immediate;
    logic [3:0]        fence_pred;
    logic [3:0]        fence_succ;
    logic [3:0]        fence_mode;
  } dec_t;

  // Base integer operation selected by funct3 for op_imm and op.
  function automatic logic [4:0] base_op(input logic [2:0] f3);
    logic [4:0] op;
    unique case (f3)
      F3_ADD:  op = OP_ADD;
      F3_SLL:  op = OP_SLL;
      F3_SLT:  op = OP_SLT;
      F3_SLTU: op = OP_SLTU;
      F3_XOR:  op = OP_XOR;
      F3_SR:   op = OP_SRL;
      F3_OR:   op = OP_OR;
      F3_AND:  op = OP_AND;
      default: op = OP_ADD;
    endcase
    return op;
  endfunction

endpackage

// ===== hw/rtl/rv64im_instruction_decoder.sv =====
`timescale 1ns / 1ps
// RV64IM instruction decoder.
// Input channel: instr_valid / instr_stall carry one 32-bit instr_word per request.
// Output channel: dec_valid / dec_stall carry the decoded fields of that word:
// is_unknown, instr_class, op_kind, operation, the three register numbers, the
// sign-extended immediate and the fence fields. An unknown word gives is_unknown
// high with every other field zero.
// A request is taken at a clock edge where valid is high and stall is low.
// The word is captured in an input register, decoded by one level of logic and
// stored in the result register. While dec_stall is low the block takes one
// request every cycle; the input and result registers form a two-entry
// pipeline.
// While the receiver holds dec_stall, the result register keeps its value and the
// input register can still take one more word; instr_stall rises only when both
// are full.
// A synchronous reset empties both registers; the block is ready in the next cycle.
`include "rv64im_instruction_decoder_macros.svh"

module rv64im_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               instr_valid,
  output logic               instr_stall,
  input  logic [31:0]        instr_word,
  output logic               dec_valid,
  input  logic               dec_stall,
  output logic               is_unknown,
  output logic [3:0]         instr_class,
  output logic [1:0]         op_kind,
  output logic [4:0]         operation,
  output logic [4:0]         rd_index,
  output logic [4:0]         rs1_index,
  output logic [4:0]         rs2_index,
  output logic signed [31:0] immediate,
  output logic [3:0]         fence_pred,
  output logic [3:0]         fence_succ,
  output logic [3:0]         fence_mode
);

  logic              word_valid;
  logic [31:0]       word;
  logic              res_valid;
  rv64id_pkg::dec_t  res;
  rv64id_pkg::dec_t  res_next;
  logic              res_load;
  logic              word_load;

  assign res_load    = !res_valid || !dec_stall;
  assign word_load   = !word_valid || res_load;
  assign instr_stall = !word_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (word_load) begin
        word_valid <= instr_valid;
      end
      if (res_load) begin
        res_valid <= word_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_load && instr_valid) begin
      word <= instr_word;
    end
    if (res_load && word_valid) begin
      res <= res_next;
    end
  end

  always_comb begin
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic        sub;
    logic        mext;
    logic        unk;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_u;
    logic [31:0] imm_j;
    rv64id_pkg::dec_t d;

    opc   = word[6:0];
    f3    = word[14:12];
    sub   = word[30];
    mext  = word[25];
    imm_i = {{20{word[31]}}, word[31:20]};
    imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
    imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    imm_u = {word[31:12], 12'b0};
    imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    unk   = 1'b0;
    d     = '0;

    unique case (opc)
      rv64id_pkg::OPC_LUI: begin
        d.instr_class = rv64id_pkg::CLS_LUI;
        d.rd_index    = word[11:7];
        d.immediate   = imm_u;
      end
      rv64id_pkg::OPC_JAL: begin
        d.instr_class = rv64id_pkg::CLS_JAL;
        d.rd_index    = word[11:7];
        d.immediate   = imm_j;
      end
      rv64id_pkg::OPC_JALR: begin
        d.instr_class = rv64id_pkg::CLS_JALR;
        d.rd_index    = word[11:7];
        d.rs1_index   = word[19:15];
        d.immediate   = imm_i;
      end
      rv64id_pkg::OPC_AUIPC: begin
        d.instr_class = rv64id_pkg::CLS_AUIPC;
        d.rd_index    = word[11:7];
        d.immediate   = imm_u;
      end
      rv64id_pkg::OPC_OP_IMM: begin
        d.instr_class = rv64id_pkg::CLS_OP_IMM;
        d.rd_index    = word[11:7];
        d.rs1_index   = word[19:15];
        d.immediate   = imm_i;
        d.operation   = rv64id_pkg::base_op(f3);
        if (f3 == rv64id_pkg::F3_SR) begin
          d.operation     = sub ? rv64id_pkg::OP_SRA : rv64id_pkg::OP_SRL;
          d.immediate[10] = 1'b0;
        end
      end
      rv64id_pkg::OPC_OP_IMM32: begin
        d.instr_class = rv64id_pkg::CLS_OP_IMM32;
        d.rd_index    = word[11:7];
        d.rs1_index   = word[19:15];
        d.immediate   = imm_i;
        unique case (f3)
          rv64id_pkg::F3_ADD: d.operation = rv64id_pkg::OP_ADDW;
          rv64id_pkg::F3_SLL: d.operation = rv64id_pkg::OP_SLLW;
          rv64id_pkg::F3_SR: begin
            d.operation     = sub ? rv64id_pkg::OP_SRAW : rv64id_pkg::OP_SRLW;
            d.immediate[10] = 1'b0;
          end
          default: unk = 1'b1;
        endcase
      end
      rv64id_pkg::OPC_OP: begin
        d.instr_class = rv64id_pkg::CLS_OP;
        d.rd_index    = word[11:7];
        d.rs1_index   = word[19:15];
        d.rs2_index   = word[24:20];
        if (mext) begin
          d.operation = rv64id_pkg::OP_MUL + {2'b00, f3};
        end else if (f3 == rv64id_pkg::F3_ADD && sub) begin
          d.operation = rv64id_pkg::OP_SUB;
        end else if (f3 == rv64id_pkg::F3_SR && sub) begin
          d.operation = rv64id_pkg::OP_SRA;
        end else begin
          d.operation = rv64id_pkg::base_op(f3);
        end
      end
      rv64id_pkg::OPC_OP32: begin
        d.instr_class = rv64id_pkg::CLS_OP32;
        d.rd_index    = word[11:7];
        d.rs1_index   = word[19:15];
        d.rs2_index   = word[24:20];
        if (!mext) begin
          unique case (f3)
            rv64id_pkg::F3_ADD: d.operation = sub ? rv64id_pkg::OP_SUBW : rv64id_pkg::OP_ADDW;
            rv64id_pkg::F3_SLL: d.operation = rv64id_pkg::OP_SLLW;
            rv64id_pkg::F3_SR:  d.operation = sub ? rv64id_pkg::OP_SRAW : rv64id_pkg::OP_SRLW;
            default:            unk = 1'b1;
          endcase
        end else begin
          unique case (f3)
            rv64id_pkg::F3_ADD: d.operation = rv64id_pkg::OP_MULW;
            rv64id_pkg::F3_XOR: d.operation = rv64id_pkg::OP_DIVW;
            rv64id_pkg::F3_SR:  d.operation = rv64id_pkg::OP_DIVUW;
            rv64id_pkg::F3_OR:  d.operation = rv64id_pkg::OP_REMW;
            rv64id_pkg::F3_AND: d.operation = rv64id_pkg::OP_REMUW;
            default:            unk = 1'b1;
          endcase
        end
      end
      rv64id_pkg::OPC_LOAD: begin
        d.instr_class = rv64id_pkg::CLS_LOAD;
        d.rd_index    = word[11:7];
        d.rs1_index   = word[19:15];
        d.immediate   = imm_i;
        d.operation   = {2'b00, f3};
        unk           = (f3 == rv64id_pkg::F3_AND);
      end
      rv64id_pkg::OPC_STORE: begin
        d.instr_class = rv64id_pkg::CLS_STORE;
        d.rs1_index   = word[19:15];
        d.rs2_index   = word[24:20];
        d.immediate   = imm_s;
        d.operation   = {2'b00, f3};
        unk           = f3[2];
      end
      rv64id_pkg::OPC_BRANCH: begin
        d.instr_class = rv64id_pkg::CLS_BR_FENCE;
        d.op_kind     = rv64id_pkg::KIND_BRANCH;
        d.rs1_index   = word[19:15];
        d.rs2_index   = word[24:20];
        d.immediate   = imm_b;
        d.operation   = {2'b00, f3};
        unk           = (f3 == rv64id_pkg::F3_SLT) || (f3 == rv64id_pkg::F3_SLTU);
      end
      rv64id_pkg::OPC_MISC_MEM: begin
        d.instr_class = rv64id_pkg::CLS_BR_FENCE;
        if (f3 == rv64id_pkg::F3_ADD) begin
          d.op_kind    = rv64id_pkg::KIND_FENCE;
          d.fence_succ = word[23:20];
          d.fence_pred = word[27:24];
          d.fence_mode = word[31:28];
        end else if (f3 == rv64id_pkg::F3_SLL) begin
          d.op_kind = rv64id_pkg::KIND_FENCE_I;
        end else begin
          unk = 1'b1;
        end
      end
      default: unk = 1'b1;
    endcase

    // An unknown word clears every field but the flag.
    if (unk) begin
      d            = '0;
      d.is_unknown = 1'b1;
    end
    res_next = d;
  end

  assign dec_valid   = res_valid;
  assign is_unknown  = res.is_unknown;
  assign instr_class = res.instr_class;
  assign op_kind     = res.op_kind;
  assign operation   = res.operation;
  assign rd_index    = res.rd_index;
  assign rs1_index   = res.rs1_index;
  assign rs2_index   = res.rs2_index;
  assign immediate   = res.immediate;
  assign fence_pred  = res.fence_pred;
  assign fence_succ  = res.fence_succ;
  assign fence_mode  = res.fence_mode;

  `RV64ID_ASSERT_RST(a_reset_empties, rst |=> !dec_valid && !word_valid)
  `RV64ID_ASSERT(a_word_moves_on, word_valid && res_load |=> dec_valid)
  `RV64ID_ASSERT(a_unknown_clears, dec_valid && is_unknown |-> instr_class == 4'd0 && operation == 5'd0 && immediate == 32'sd0 && rd_index == 5'd0)
  `RV64ID_ASSERT(a_fence_only, dec_valid && (fence_pred != 4'd0 || fence_succ != 4'd0 || fence_mode != 4'd0) |-> instr_class == rv64id_pkg::CLS_BR_FENCE && op_kind == rv64id_pkg::KIND_FENCE)
  `RV64ID_ASSERT(a_full_stalls, word_valid && dec_valid && dec_stall |-> instr_stall)

endmodule

// ===== tb/rv64im_instruction_decoder_tb.sv =====
`timescale 1ns / 1ps

module rv64im_instruction_decoder_tb;

  localparam int RANDOM_PER_MIX = 550;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int DIR_ROWS = 28;

  // funct3 values that the package does not name.
  localparam logic [2:0] F3_FENCE     = 3'b000;
  localparam logic [2:0] F3_FENCE_I   = 3'b001;
  localparam logic [2:0] F3_LOAD_RSVD = 3'b111;
  localparam logic [2:0] F3_BR_RSVD_A = 3'b010;
  localparam logic [2:0] F3_BR_RSVD_B = 3'b011;

  localparam rv64id_pkg::dec_t UNKNOWN_DECODE = '{is_unknown: 1'b1, default: '0};
  localparam rv64id_pkg::dec_t LUI_TOP = '{instr_class: rv64id_pkg::CLS_LUI,
                                           immediate: 32'hFFFF_F000, default: '0};

  localparam logic [6:0] MAJOR_OPCODES [12] = '{
    rv64id_pkg::OPC_LUI, rv64id_pkg::OPC_JAL, rv64id_pkg::OPC_JALR,
    rv64id_pkg::OPC_AUIPC, rv64id_pkg::OPC_OP_IMM, rv64id_pkg::OPC_OP_IMM32,
    rv64id_pkg::OPC_OP, rv64id_pkg::OPC_OP32, rv64id_pkg::OPC_LOAD,
    rv64id_pkg::OPC_STORE, rv64id_pkg::OPC_BRANCH, rv64id_pkg::OPC_MISC_MEM
  };

  localparam int TX_IDLE_PCT [3] = '{33, 71, 0};
  localparam int RX_IDLE_PCT [3] = '{71, 33, 0};

  typedef struct packed {
    logic [31:0]      word;
    logic             typed;
    rv64id_pkg::dec_t result;
  } dir_row_t;

  // Rows marked typed carry their decode; the rest go through the predictor.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{32'h0000_0000, 1'b1, UNKNOWN_DECODE},
    '{32'hFFFF_FFFF, 1'b1, UNKNOWN_DECODE},
    '{32'hFFFF_F037, 1'b1, LUI_TOP},
    '{32'h0000_0037, 1'b1, '0},  // lui x0, 0 decodes to all zeros
    '{32'hFFFF_FFEF, 1'b0, '0},
    '{32'h8000_0067, 1'b0, '0},
    '{32'hFFFF_FF97, 1'b0, '0},
    '{32'h7FF1_0093, 1'b0, '0},
    '{32'h40F0_D113, 1'b0, '0},
    '{32'hFFF0_D013, 1'b0, '0},
    '{32'h4031_00B3, 1'b0, '0},
    '{32'hFFFF_D0B3, 1'b0, '0},
    '{32'h0231_00B3, 1'b0, '0},
    '{32'h4031_D0BB, 1'b0, '0},
    '{32'h0000_203B, 1'b1, UNKNOWN_DECODE},
    '{32'h0200_103B, 1'b1, UNKNOWN_DECODE},
    '{32'h0000_201B, 1'b1, UNKNOWN_DECODE},
    '{32'h4050_D09B, 1'b0, '0},
    '{32'h8001_3083, 1'b0, '0},
    '{32'h0000_7003, 1'b1, UNKNOWN_DECODE},
    '{32'hFE31_3FA3, 1'b0, '0},
    '{32'h0000_4023, 1'b1, UNKNOWN_DECODE},
    '{32'hFFF0_DFE3, 1'b0, '0},
    '{32'h0000_2063, 1'b1, UNKNOWN_DECODE},
    '{32'h0000_3063, 1'b1, UNKNOWN_DECODE},
    '{32'hFFFF_880F, 1'b0, '0},
    '{32'hFFFF_900F, 1'b0, '0},
    '{32'h0000_200F, 1'b1, UNKNOWN_DECODE}
  };

  typedef struct {
    logic [31:0]      word;
    rv64id_pkg::dec_t result;
  } pending_decode_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               instr_valid = 1'b0;
  logic               instr_stall;
  logic [31:0]        instr_word = '0;
  logic               dec_valid;
  logic               dec_stall = 1'b0;
  logic               is_unknown;
  logic [3:0]         instr_class;
  logic [1:0]         op_kind;
  logic [4:0]         operation;
  logic [4:0]         rd_index;
  logic [4:0]         rs1_index;
  logic [4:0]         rs2_index;
  logic signed [31:0] immediate;
  logic [3:0]         fence_pred;
  logic [3:0]         fence_succ;
  logic [3:0]         fence_mode;

  pending_decode_t pending_decodes[$];
  int mismatches = 0;
  int requests_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;

  rv64im_instruction_decoder dut (
    .clk(clk),
    .rst(rst),
    .instr_valid(instr_valid),
    .instr_stall(instr_stall),
    .instr_word(instr_word),
    .dec_valid(dec_valid),
    .dec_stall(dec_stall),
    .is_unknown(is_unknown),
    .instr_class(instr_class),
    .op_kind(op_kind),
    .operation(operation),
    .rd_index(rd_index),
    .rs1_index(rs1_index),
    .rs2_index(rs2_index),
    .immediate(immediate),
    .fence_pred(fence_pred),
    .fence_succ(fence_succ),
    .fence_mode(fence_mode)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("rv64im_instruction_decoder_tb NOT OK");
    $finish;
  end

  function automatic logic [4:0] integer_op(input logic [2:0] f3);
    unique case (f3)
      rv64id_pkg::F3_ADD:  return rv64id_pkg::OP_ADD;
      rv64id_pkg::F3_SLL:  return rv64id_pkg::OP_SLL;
      rv64id_pkg::F3_SLT:  return rv64id_pkg::OP_SLT;
      rv64id_pkg::F3_SLTU: return rv64id_pkg::OP_SLTU;
      rv64id_pkg::F3_XOR:  return rv64id_pkg::OP_XOR;
      rv64id_pkg::F3_SR:   return rv64id_pkg::OP_SRL;
      rv64id_pkg::F3_OR:   return rv64id_pkg::OP_OR;
      default:             return rv64id_pkg::OP_AND;
    endcase
  endfunction

  function automatic rv64id_pkg::dec_t decode_word(input logic [31:0] w);
    rv64id_pkg::dec_t d;
    logic [31:0] imm_i;
    logic [2:0] f3;
    logic bad;
    d = '0;
    bad = 1'b0;
    f3 = w[14:12];
    imm_i = {{20{w[31]}}, w[31:20]};
    unique case (w[6:0])
      rv64id_pkg::OPC_LUI: begin
        d.instr_class = rv64id_pkg::CLS_LUI;
        d.rd_index = w[11:7];
        d.immediate = {w[31:12], 12'h000};
      end
      rv64id_pkg::OPC_AUIPC: begin
        d.instr_class = rv64id_pkg::CLS_AUIPC;
        d.rd_index = w[11:7];
        d.immediate = {w[31:12], 12'h000};
      end
      rv64id_pkg::OPC_JAL: begin
        d.instr_class = rv64id_pkg::CLS_JAL;
        d.rd_index = w[11:7];
        d.immediate = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      end
      rv64id_pkg::OPC_JALR: begin
        d.instr_class = rv64id_pkg::CLS_JALR;
        d.rd_index = w[11:7];
        d.rs1_index = w[19:15];
        d.immediate = imm_i;
      end
      rv64id_pkg::OPC_OP_IMM: begin
        d.instr_class = rv64id_pkg::CLS_OP_IMM;
        d.rd_index = w[11:7];
        d.rs1_index = w[19:15];
        d.immediate = imm_i;
        d.operation = integer_op(f3);
        // Right shifts use bit 30 to pick sra, and that bit is dropped from the shamt.
        if (f3 == rv64id_pkg::F3_SR) begin
          if (w[30]) d.operation = rv64id_pkg::OP_SRA;
          d.immediate[10] = 1'b0;
        end
      end
      rv64id_pkg::OPC_OP_IMM32: begin
        d.instr_class = rv64id_pkg::CLS_OP_IMM32;
        d.rd_index = w[11:7];
        d.rs1_index = w[19:15];
        d.immediate = imm_i;
        unique case (f3)
          rv64id_pkg::F3_ADD: d.operation = rv64id_pkg::OP_ADDW;
          rv64id_pkg::F3_SLL: d.operation = rv64id_pkg::OP_SLLW;
          rv64id_pkg::F3_SR: begin
            d.operation = w[30] ? rv64id_pkg::OP_SRAW : rv64id_pkg::OP_SRLW;
            d.immediate[10] = 1'b0;
          end
          default: bad = 1'b1;
        endcase
      end
      rv64id_pkg::OPC_OP: begin
        d.instr_class = rv64id_pkg::CLS_OP;
        d.rd_index = w[11:7];
        d.rs1_index = w[19:15];
        d.rs2_index = w[24:20];
        if (w[25]) begin
          d.operation = 5'(rv64id_pkg::OP_MUL + f3);
        end else begin
          d.operation = integer_op(f3);
          if (w[30] && f3 == rv64id_pkg::F3_ADD) d.operation = rv64id_pkg::OP_SUB;
          if (w[30] && f3 == rv64id_pkg::F3_SR) d.operation = rv64id_pkg::OP_SRA;
        end
      end
      rv64id_pkg::OPC_OP32: begin
        d.instr_class = rv64id_pkg::CLS_OP32;
        d.rd_index = w[11:7];
        d.rs1_index = w[19:15];
        d.rs2_index = w[24:20];
        if (!w[25]) begin
          unique case (f3)
            rv64id_pkg::F3_ADD:
              d.operation = w[30] ? rv64id_pkg::OP_SUBW : rv64id_pkg::OP_ADDW;
            rv64id_pkg::F3_SLL: d.operation = rv64id_pkg::OP_SLLW;
            rv64id_pkg::F3_SR:
              d.operation = w[30] ? rv64id_pkg::OP_SRAW : rv64id_pkg::OP_SRLW;
            default: bad = 1'b1;
          endcase
        end else begin
          unique case (f3)
            rv64id_pkg::F3_ADD: d.operation = rv64id_pkg::OP_MULW;
            rv64id_pkg::F3_XOR: d.operation = rv64id_pkg::OP_DIVW;
            rv64id_pkg::F3_SR:  d.operation = rv64id_pkg::OP_DIVUW;
            rv64id_pkg::F3_OR:  d.operation = rv64id_pkg::OP_REMW;
            rv64id_pkg::F3_AND: d.operation = rv64id_pkg::OP_REMUW;
            default:            bad = 1'b1;
          endcase
        end
      end
      rv64id_pkg::OPC_LOAD: begin
        d.instr_class = rv64id_pkg::CLS_LOAD;
        d.rd_index = w[11:7];
        d.rs1_index = w[19:15];
        d.immediate = imm_i;
        d.operation = {2'b00, f3};
        bad = (f3 == F3_LOAD_RSVD);
      end
      rv64id_pkg::OPC_STORE: begin
        d.instr_class = rv64id_pkg::CLS_STORE;
        d.rs1_index = w[19:15];
        d.rs2_index = w[24:20];
        d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        d.operation = {2'b00, f3};
        // Only byte through doubleword widths exist, so funct3 bit 2 must be clear.
        bad = f3[2];
      end
      rv64id_pkg::OPC_BRANCH: begin
        d.instr_class = rv64id_pkg::CLS_BR_FENCE;
        d.op_kind = rv64id_pkg::KIND_BRANCH;
        d.rs1_index = w[19:15];
        d.rs2_index = w[24:20];
        d.immediate = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        d.operation = {2'b00, f3};
        bad = (f3 == F3_BR_RSVD_A) || (f3 == F3_BR_RSVD_B);
      end
      rv64id_pkg::OPC_MISC_MEM: begin
        d.instr_class = rv64id_pkg::CLS_BR_FENCE;
        unique case (f3)
          F3_FENCE: begin
            d.op_kind = rv64id_pkg::KIND_FENCE;
            d.fence_succ = w[23:20];
            d.fence_pred = w[27:24];
            d.fence_mode = w[31:28];
          end
          F3_FENCE_I: d.op_kind = rv64id_pkg::KIND_FENCE_I;
          default: bad = 1'b1;
        endcase
      end
      default: bad = 1'b1;
    endcase
    if (bad) d = UNKNOWN_DECODE;
    return d;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] decode mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input logic [31:0] word);
    if (got !== want)
      report_mismatch($sformatf("word %h %s got %0h expected %0h", word, name, got, want));
  endtask

  task automatic offer_word(input logic [31:0] word, input logic typed,
                            input rv64id_pkg::dec_t given);
    pending_decode_t entry;
    instr_valid <= 1'b1;
    instr_word <= word;
    @(posedge clk);
    while (instr_stall) @(posedge clk);
    entry.word = word;
    entry.result = typed ? given : decode_word(word);
    pending_decodes.push_back(entry);
    requests_sent++;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      dec_stall <= 1'b1;
    end else if (hold_requests != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= HOLD_OFF_CYCLES;
      dec_stall <= 1'b1;
    end else begin
      dec_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    pending_decode_t head;
    if (!rst && dec_valid && !dec_stall) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("decoded result with no request outstanding");
      end else begin
        head = pending_decodes.pop_front();
        check_field("is_unknown", is_unknown, head.result.is_unknown, head.word);
        check_field("instr_class", instr_class, head.result.instr_class, head.word);
        check_field("op_kind", op_kind, head.result.op_kind, head.word);
        check_field("operation", operation, head.result.operation, head.word);
        check_field("rd_index", rd_index, head.result.rd_index, head.word);
        check_field("rs1_index", rs1_index, head.result.rs1_index, head.word);
        check_field("rs2_index", rs2_index, head.result.rs2_index, head.word);
        check_field("immediate", immediate, head.result.immediate, head.word);
        check_field("fence_pred", fence_pred, head.result.fence_pred, head.word);
        check_field("fence_succ", fence_succ, head.result.fence_succ, head.word);
        check_field("fence_mode", fence_mode, head.result.fence_mode, head.word);
      end
    end
  end

  initial begin
    logic [31:0] word;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++)
      offer_word(DIR_TABLE[r].word, DIR_TABLE[r].typed, DIR_TABLE[r].result);

    for (int mix = 0; mix < 3; mix++) begin
      tx_idle_pct = TX_IDLE_PCT[mix];
      rx_idle_pct = RX_IDLE_PCT[mix];
      for (int n = 0; n < RANDOM_PER_MIX; n++) begin
        // Long receiver hold-off while requests keep coming, so the input backs up.
        if (n == 100) hold_requests <= hold_requests + 1;
        if (n == 300) begin
          instr_valid <= 1'b0;
          @(posedge clk);
          while (pending_decodes.size() != 0) @(posedge clk);
        end
        while ($urandom_range(99) < tx_idle_pct) begin
          instr_valid <= 1'b0;
          @(posedge clk);
        end
        // Mostly legal major opcodes with random fields; the rest is raw noise.
        word = $urandom();
        if ($urandom_range(9) != 0) word[6:0] = MAJOR_OPCODES[$urandom_range(11)];
        offer_word(word, 1'b0, '0);
      end
    end

    instr_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Decoded %0d instruction words: %0d table rows, then random words under three",
             requests_sent, DIR_ROWS);
    $display("sender/receiver idle mixes with a long result hold-off and a full drain in each.");
    if (mismatches == 0) begin
      $display("rv64im_instruction_decoder_tb OK");
    end else begin
      $display("rv64im_instruction_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rv64id_pkg.sv
hw/rtl/rv64im_instruction_decoder.sv
tb/rv64im_instruction_decoder_tb.sv
